@@ sv/les_pkg.sv @@
// Shared types, constants, tables and microcode for the LED scanner eye sequencer.
// No dependencies; every other file imports this package.
package les_pkg;

	localparam int STRIP_LENGTH = 64;
	localparam int DEFAULT_EYE  = 8;
	localparam int MAX_EYE      = STRIP_LENGTH - 3;

	// dim level = level / 10, exact for 8-bit levels: (x * 205) >> 11
	localparam logic [7:0] DIM_MUL   = 8'd205;
	localparam int         DIM_SHIFT = 11;

	typedef logic [5:0] pix_t;
	typedef logic [2:0] step_t;

	// register indexes on the config port
	localparam logic [2:0] REG_RED   = 3'd0;
	localparam logic [2:0] REG_GREEN = 3'd1;
	localparam logic [2:0] REG_BLUE  = 3'd2;
	localparam logic [2:0] REG_EYE   = 3'd3;
	localparam logic [2:0] REG_SPEED = 3'd4;

	// microprogram steps
	localparam step_t STEP_IDLE    = 3'd0;
	localparam step_t STEP_TEST    = 3'd1;
	localparam step_t STEP_LOAD    = 3'd2;
	localparam step_t STEP_EMIT    = 3'd3;
	localparam step_t STEP_ADVANCE = 3'd4;

	typedef enum logic [1:0] {
		KIND_RTL = 2'd0,
		KIND_LTR = 2'd1,
		KIND_OTC = 2'd2,
		KIND_CTO = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_NOP     = 2'd0,
		OP_DEC     = 2'd1,
		OP_LOAD    = 2'd2,
		OP_ADVANCE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER    = 3'd0,
		COND_ALWAYS   = 3'd1,
		COND_NO_TICK  = 3'd2,
		COND_WAIT_NZ  = 3'd3,
		COND_NOT_DONE = 3'd4
	} cond_t;

	typedef struct packed {
		logic  in_ready;
		logic  out_valid;
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	// datapath controls issued by the sequencer
	typedef struct packed {
		logic in_ready;
		logic out_valid;
		op_t  op;
	} ctrl_t;

	// conditions fed back to the sequencer
	typedef struct packed {
		logic tick_item;
		logic out_fire;
		logic wait_nz;
		logic last_pixel;
	} status_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [5:0] eye_size;
		logic [2:0] speed;
	} cfg_t;

	function automatic uword_t microcode(step_t s);
		uword_t w;
		unique case (s)
			STEP_IDLE:    w = '{1'b1, 1'b0, OP_NOP,     COND_NO_TICK,  STEP_IDLE};
			STEP_TEST:    w = '{1'b0, 1'b0, OP_DEC,     COND_WAIT_NZ,  STEP_IDLE};
			STEP_LOAD:    w = '{1'b0, 1'b0, OP_LOAD,    COND_NEVER,    STEP_IDLE};
			STEP_EMIT:    w = '{1'b0, 1'b1, OP_NOP,     COND_NOT_DONE, STEP_EMIT};
			STEP_ADVANCE: w = '{1'b0, 1'b0, OP_ADVANCE, COND_ALWAYS,   STEP_IDLE};
			default:      w = '{1'b0, 1'b0, OP_NOP,     COND_ALWAYS,   STEP_IDLE};
		endcase
		return w;
	endfunction

	function automatic kind_t phase_kind(logic [2:0] ph);
		kind_t k;
		case (ph)
			3'd0:    k = KIND_RTL;
			3'd1:    k = KIND_LTR;
			3'd2:    k = KIND_OTC;
			3'd3:    k = KIND_CTO;
			3'd4:    k = KIND_LTR;
			3'd5:    k = KIND_RTL;
			3'd6:    k = KIND_OTC;
			default: k = KIND_CTO;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] frame_delay(logic [2:0] sp);
		logic [7:0] d;
		case (sp)
			3'd0:    d = 8'd50;
			3'd1:    d = 8'd30;
			3'd2:    d = 8'd20;
			3'd3:    d = 8'd10;
			default: d = 8'd5;
		endcase
		return d;
	endfunction

	function automatic logic [7:0] return_delay(logic [2:0] sp);
		logic [7:0] d;
		case (sp)
			3'd0:    d = 8'd150;
			3'd1:    d = 8'd120;
			3'd2:    d = 8'd60;
			3'd3:    d = 8'd30;
			default: d = 8'd10;
		endcase
		return d;
	endfunction

endpackage

@@ sv/les_cfg_regs.sv @@
// Configuration register file for the LED scanner eye sequencer.
// Depends on les_pkg (cfg_t, register indexes).
module les_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [7:0]     cfg_data,
	output les_pkg::cfg_t  cfg
);
	import les_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red      <= 8'd255;
			cfg_q.green    <= 8'd0;
			cfg_q.blue     <= 8'd0;
			cfg_q.eye_size <= 6'(DEFAULT_EYE);
			cfg_q.speed    <= 3'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RED:   cfg_q.red      <= cfg_data;
				REG_GREEN: cfg_q.green    <= cfg_data;
				REG_BLUE:  cfg_q.blue     <= cfg_data;
				REG_EYE:   cfg_q.eye_size <= cfg_data[5:0];
				REG_SPEED: cfg_q.speed    <= cfg_data[2:0];
				default:   ; // unknown index: dropped
			endcase
		end
	end

endmodule

@@ sv/les_sequencer.sv @@
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on les_pkg (microcode, ctrl_t, status_t).
module les_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  les_pkg::status_t status,
	output les_pkg::ctrl_t   ctrl
);
	import les_pkg::*;

	step_t  step_q;
	step_t  step_next;
	uword_t uw;
	logic   take_jump;

	assign uw = microcode(step_q);

	always_comb begin
		ctrl.in_ready  = uw.in_ready;
		ctrl.out_valid = uw.out_valid;
		ctrl.op        = uw.op;
	end

	always_comb begin
		unique case (uw.cond)
			COND_NEVER:    take_jump = 1'b0;
			COND_ALWAYS:   take_jump = 1'b1;
			COND_NO_TICK:  take_jump = !status.tick_item;
			COND_WAIT_NZ:  take_jump = status.wait_nz;
			COND_NOT_DONE: take_jump = !(status.out_fire && status.last_pixel);
			default:       take_jump = 1'b1;
		endcase
		step_next = take_jump ? uw.target : step_t'(step_q + 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

	// input and output sides never open together
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.in_ready && ctrl.out_valid))
		else $error("in_ready and out_valid both high");

	// last pixel taken -> advance step follows
	assert property (@(posedge clk) disable iff (!arst_n)
		(status.out_fire && status.last_pixel) |=> (step_q == STEP_ADVANCE))
		else $error("frame end not followed by advance");

	// pending wait count aborts the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_TEST && status.wait_nz) |=> (step_q == STEP_IDLE))
		else $error("tick with nonzero wait did not return to idle");

endmodule

@@ sv/les_datapath.sv @@
// Datapath: wait counter, phase and eye position, pixel counter and pixel shading.
// Depends on les_pkg (tables, cfg_t, ctrl_t, kind_t).
module les_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  les_pkg::ctrl_t ctrl,
	input  les_pkg::cfg_t  cfg,
	input  logic           out_fire,
	output logic           wait_nz,
	output logic           last_pixel,
	output logic [5:0]     pixel_index,
	output logic [7:0]     pixel_red,
	output logic [7:0]     pixel_green,
	output logic [7:0]     pixel_blue
);
	import les_pkg::*;

	logic [7:0] wait_q;
	logic [2:0] phase_q;
	pix_t       pos_q;
	pix_t       pix_q;
	logic [5:0] eff_q;
	logic [7:0] dim_red_q, dim_green_q, dim_blue_q;

	logic [5:0]  eff_eye;
	logic [2:0]  eff_speed;
	logic [15:0] prod_red, prod_green, prod_blue;
	kind_t       kind;
	logic        mirrored;

	logic signed [8:0] p_s, i_s, e_s, top_s;
	logic f_dim, f_full, s_dim, s_full, dim, full;

	logic              at_end;
	logic signed [8:0] span_s, half_s;
	kind_t             next_kind;
	logic [2:0]        next_phase;
	pix_t              next_pos;
	logic [7:0]        reload;

	assign eff_eye   = (cfg.eye_size > 6'(MAX_EYE)) ? 6'(MAX_EYE) : cfg.eye_size;
	assign eff_speed = (cfg.speed > 3'd4) ? 3'd4 : cfg.speed;

	assign prod_red   = 16'(cfg.red)   * 16'(DIM_MUL);
	assign prod_green = 16'(cfg.green) * 16'(DIM_MUL);
	assign prod_blue  = 16'(cfg.blue)  * 16'(DIM_MUL);

	assign kind     = phase_kind(phase_q);
	assign mirrored = (kind == KIND_OTC) || (kind == KIND_CTO);

	// shading of pixel pix_q
	always_comb begin
		p_s    = $signed({3'b000, pix_q});
		i_s    = $signed({3'b000, pos_q});
		e_s    = $signed({3'b000, eff_q});
		top_s  = 9'(STRIP_LENGTH) - i_s;
		f_dim  = (p_s == i_s) || (p_s == i_s + e_s + 9'sd1);
		f_full = (p_s > i_s) && (p_s <= i_s + e_s);
		s_dim  = mirrored && ((p_s == top_s) || (p_s == top_s - e_s - 9'sd1));
		s_full = mirrored && (p_s >= top_s - e_s) && (p_s < top_s);
		if (s_dim || s_full) begin
			full = s_full;
			dim  = !s_full;
		end else begin
			full = f_full && !f_dim;
			dim  = f_dim;
		end
	end

	assign pixel_index = pix_q;
	assign pixel_red   = full ? cfg.red   : (dim ? dim_red_q   : 8'd0);
	assign pixel_green = full ? cfg.green : (dim ? dim_green_q : 8'd0);
	assign pixel_blue  = full ? cfg.blue  : (dim ? dim_blue_q  : 8'd0);

	assign wait_nz    = (wait_q != 8'd0);
	assign last_pixel = (pix_q == 6'(STRIP_LENGTH - 1));

	// end-of-frame position, phase and wait reload update
	always_comb begin
		span_s = 9'(STRIP_LENGTH) - $signed({3'b000, eff_q});
		half_s = span_s >>> 1;
		case (kind)
			KIND_RTL: at_end = (pos_q <= 6'd1);
			KIND_LTR: at_end = ($signed({3'b000, pos_q}) >= span_s - 9'sd3);
			KIND_OTC: at_end = ($signed({3'b000, pos_q}) >= half_s);
			default:  at_end = (pos_q == 6'd0);
		endcase
		next_phase = phase_q + 3'd1;
		next_kind  = phase_kind(next_phase);
		reload     = frame_delay(eff_speed) - 8'd1;
		if (at_end) begin
			reload = reload + return_delay(eff_speed);
			case (next_kind)
				KIND_RTL: next_pos = span_s[5:0] - 6'd2;
				KIND_CTO: next_pos = half_s[5:0];
				default:  next_pos = 6'd0;
			endcase
		end else if (kind == KIND_RTL || kind == KIND_CTO) begin
			next_pos = pos_q - 6'd1;
		end else begin
			next_pos = pos_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q  <= 8'd0;
			phase_q <= 3'd0;
			pos_q   <= 6'(STRIP_LENGTH - DEFAULT_EYE - 2);
			pix_q   <= '0;
		end else begin
			case (ctrl.op)
				OP_DEC: begin
					if (wait_nz) wait_q <= wait_q - 8'd1;
				end
				OP_LOAD: begin
					pix_q <= '0;
				end
				OP_ADVANCE: begin
					wait_q <= reload;
					pos_q  <= next_pos;
					if (at_end) phase_q <= next_phase;
				end
				default: ;
			endcase
			if (out_fire) pix_q <= pix_q + 6'd1;
		end
	end

	// frame snapshot: eye size and dim levels
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_LOAD) begin
			eff_q       <= eff_eye;
			dim_red_q   <= {3'b000, prod_red[DIM_SHIFT +: 5]};
			dim_green_q <= {3'b000, prod_green[DIM_SHIFT +: 5]};
			dim_blue_q  <= {3'b000, prod_blue[DIM_SHIFT +: 5]};
		end
	end

	// largest reload is the slowest frame delay plus its return delay
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_ADVANCE) |=> (wait_q < 8'd200))
		else $error("wait reload out of range");

	// the eye never starts past the strip
	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 6'(STRIP_LENGTH - 2))
		else $error("eye position beyond strip");

endmodule

@@ sv/led_scanner_eye_sequencer.sv @@
// The first pixel item is offered after a due tick item is taken and the test and load steps
// have run; with a ready sink the frame then streams one pixel item per cycle, set by the
// emit step of the microprogram. A due tick runs the test, load, emit and advance steps, a
// tick with a nonzero wait count only decrements the wait, a non-tick item leaves it idle.
// Reset (arst_n low, asynchronous): registers to defaults, phase 0, wait count 0,
// so the first tick item produces a frame.
module led_scanner_eye_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// tick input, tdata: [0] tick, [7:1] zero
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	// pixel output, tdata: [5:0] pixel_index, [13:6] pixel_red, [21:14] pixel_green,
	// [29:22] pixel_blue, [31:30] zero; tlast: frame_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast,
	// register writes: index 0 red, 1 green, 2 blue, 3 eye_size, 4 speed_index
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import les_pkg::*;

	cfg_t    cfg;
	ctrl_t   ctrl;
	status_t status;
	logic    in_fire, out_fire;
	logic    wait_nz, last_pixel;
	logic [5:0] pixel_index;
	logic [7:0] pixel_red, pixel_green, pixel_blue;

	les_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshakes: input opens only in the idle step, output only while emitting
	assign s_axis_tready = ctrl.in_ready;
	assign m_axis_tvalid = ctrl.out_valid;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_fire      = m_axis_tvalid && m_axis_tready;

	always_comb begin
		status.tick_item  = in_fire && s_axis_tdata[0];
		status.out_fire   = out_fire;
		status.wait_nz    = wait_nz;
		status.last_pixel = last_pixel;
	end

	les_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	les_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.cfg         (cfg),
		.out_fire    (out_fire),
		.wait_nz     (wait_nz),
		.last_pixel  (last_pixel),
		.pixel_index (pixel_index),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue)
	);

	assign m_axis_tdata = {2'b00, pixel_blue, pixel_green, pixel_red, pixel_index};
	assign m_axis_tlast = last_pixel;

endmodule

@@ tb/led_scanner_eye_sequencer_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for led_scanner_eye_sequencer: tick items in, pixel items out.
// Depends on les_pkg for register indexes, the phase kind enum and the strip size.

typedef struct packed {
	logic [5:0] pixel;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       frame_end;
} pixel_item_t;

// Tracks registers, phase, eye position and wait count; renders each due frame.
class eye_frames;
	les_pkg::kind_t sweep_order[8];
	int             frame_gap[5];
	int             return_gap[5];
	logic [7:0]     red, green, blue;
	logic [5:0]     eye_size;
	logic [2:0]     speed;
	logic [2:0]     phase;
	logic [5:0]     position;
	logic [7:0]     wait_count;
	pixel_item_t    due_pixels[$];
	int             errors, printed, ticks, frames, phase_turns, pixels_checked;

	function new();
		sweep_order = '{les_pkg::KIND_RTL, les_pkg::KIND_LTR, les_pkg::KIND_OTC,
			les_pkg::KIND_CTO, les_pkg::KIND_LTR, les_pkg::KIND_RTL,
			les_pkg::KIND_OTC, les_pkg::KIND_CTO};
		frame_gap  = '{50, 30, 20, 10, 5};
		return_gap = '{150, 120, 60, 30, 10};
		red        = 8'd255;
		green      = 8'd0;
		blue       = 8'd0;
		eye_size   = 6'(les_pkg::DEFAULT_EYE);
		speed      = 3'd0;
		phase      = 3'd0;
		wait_count = 8'd0;
		position   = 6'(start_of(3'd0, eye_width()));
		errors = 0; printed = 0; ticks = 0; frames = 0; phase_turns = 0; pixels_checked = 0;
	endfunction

	// oversized eyes are clipped so every phase keeps at least one step
	function int eye_width();
		int e;
		e = int'(eye_size);
		if (e > les_pkg::MAX_EYE)
			e = les_pkg::MAX_EYE;
		return e;
	endfunction

	function int start_of(logic [2:0] ph, int e);
		case (sweep_order[ph])
			les_pkg::KIND_RTL: return les_pkg::STRIP_LENGTH - e - 2;
			les_pkg::KIND_CTO: return (les_pkg::STRIP_LENGTH - e) / 2;
			default:           return 0;
		endcase
	endfunction

	function void write_reg(logic [2:0] idx, logic [7:0] data);
		case (idx)
			les_pkg::REG_RED:   red = data;
			les_pkg::REG_GREEN: green = data;
			les_pkg::REG_BLUE:  blue = data;
			les_pkg::REG_EYE:   eye_size = data[5:0];
			les_pkg::REG_SPEED: speed = data[2:0];
			default: ;
		endcase
	endfunction

	// 0 black, 1 border, 2 full; the mirrored eye overrides where it lands
	function int shade(int p, int i, int e, bit mirrored);
		int lvl, top;
		lvl = 0;
		if (p == i || p == i + e + 1)
			lvl = 1;
		else if (p > i && p <= i + e)
			lvl = 2;
		if (mirrored) begin
			top = les_pkg::STRIP_LENGTH - i;
			if (p == top || p == top - e - 1)
				lvl = 1;
			else if (p >= top - e && p < top)
				lvl = 2;
		end
		return lvl;
	endfunction

	function void render_frame();
		int          e, i, lvl, sp, reload;
		bit          mirrored, done;
		les_pkg::kind_t k;
		pixel_item_t px;
		e        = eye_width();
		i        = int'(position);
		k        = sweep_order[phase];
		mirrored = (k == les_pkg::KIND_OTC || k == les_pkg::KIND_CTO);
		for (int p = 0; p < les_pkg::STRIP_LENGTH; p++) begin
			lvl          = shade(p, i, e, mirrored);
			px.pixel     = 6'(p);
			px.red       = (lvl == 2) ? red   : (lvl == 1) ? red / 8'd10   : 8'd0;
			px.green     = (lvl == 2) ? green : (lvl == 1) ? green / 8'd10 : 8'd0;
			px.blue      = (lvl == 2) ? blue  : (lvl == 1) ? blue / 8'd10  : 8'd0;
			px.frame_end = (p == les_pkg::STRIP_LENGTH - 1);
			due_pixels.push_back(px);
		end
		frames++;
		case (k)
			les_pkg::KIND_RTL: done = (i <= 1);
			les_pkg::KIND_LTR: done = (i >= les_pkg::STRIP_LENGTH - e - 3);
			les_pkg::KIND_OTC: done = (i >= (les_pkg::STRIP_LENGTH - e) / 2);
			default:           done = (i <= 0);
		endcase
		sp     = (speed > 3'd4) ? 4 : int'(speed);
		reload = frame_gap[sp] - 1;
		if (done) begin
			reload += return_gap[sp];
			phase = phase + 3'd1;
			phase_turns++;
			position = 6'(start_of(phase, e));
		end else if (k == les_pkg::KIND_RTL || k == les_pkg::KIND_CTO) begin
			position = 6'(i - 1);
		end else begin
			position = 6'(i + 1);
		end
		wait_count = 8'(reload);
	endfunction

	function void note_tick(logic tick);
		if (!tick)
			return;
		ticks++;
		if (wait_count != 8'd0) begin
			wait_count = wait_count - 8'd1;
			return;
		end
		render_frame();
	endfunction

	// one line per mismatch, quiet after the first 30
	task report(string what, int got, int want, int at);
		errors++;
		if (printed < 30) begin
			printed++;
			$display("mismatch %s at pixel %0d: got %0d, want %0d", what, at, got, want);
		end
	endtask

	task check_pixel(pixel_item_t got);
		pixel_item_t want;
		if (due_pixels.size() == 0) begin
			report("pixel item with nothing pending", int'(got.pixel), -1, int'(got.pixel));
			return;
		end
		want = due_pixels.pop_front();
		pixels_checked++;
		if (got.pixel !== want.pixel)
			report("pixel_index", int'(got.pixel), int'(want.pixel), int'(want.pixel));
		if (got.red !== want.red)
			report("pixel_red", int'(got.red), int'(want.red), int'(want.pixel));
		if (got.green !== want.green)
			report("pixel_green", int'(got.green), int'(want.green), int'(want.pixel));
		if (got.blue !== want.blue)
			report("pixel_blue", int'(got.blue), int'(want.blue), int'(want.pixel));
		if (got.frame_end !== want.frame_end)
			report("frame_end", int'(got.frame_end), int'(want.frame_end), int'(want.pixel));
	endtask
endclass

module led_scanner_eye_sequencer_tb;
	import les_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 10;
	// after the last pixel the block still runs its advance step; a counting tick its test step
	localparam int SETTLE_CYCLES  = 8;
	// longest quiet stretch in a good run is the longest pick_pause gap or stall plus the block's own steps
	localparam int WATCHDOG_LIMIT = 1000;
	// total tick items sent, directed part included
	localparam int ITEM_COUNT     = 200;
	localparam logic [2:0] NO_REG_FIRST = REG_SPEED + 3'd1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;   // [0] tick, [7:1] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;          // [5:0] index, [13:6] red, [21:14] green, [29:22] blue
	logic        m_axis_tlast;          // frame_end
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 3'd0;
	logic [7:0]  cfg_data = 8'd0;

	eye_frames frames = new();
	bit        calm = 1'b0;      // no gaps and no stalls while set
	int        idle_cycles = 0;
	int        settings_used = 0;
	int        items_sent = 0;

	led_scanner_eye_sequencer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// mostly short pauses, now and then a long one
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 3))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// pixel sink: check on the pre-edge sample, then set ready for the next cycle
	initial begin : pixel_sink
		pixel_item_t got;
		int          hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.pixel     = m_axis_tdata[5:0];
				got.red       = m_axis_tdata[13:6];
				got.green     = m_axis_tdata[21:14];
				got.blue      = m_axis_tdata[29:22];
				got.frame_end = m_axis_tlast;
				frames.check_pixel(got);
			end
			if (hold > 0)
				hold--;
			else
				hold = pick_pause();
			m_axis_tready <= (hold == 0);
		end
	end

	// watchdog: any handshake on any channel counts as progress
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", idle_cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// one tick item; valid stays up across back-to-back items
	task automatic send_tick(logic tick);
		int gap;
		gap = pick_pause();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, tick};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		items_sent++;
		frames.note_tick(tick);
	endtask

	// register write; the caller drops cfg_valid after its last write
	task automatic write_reg(logic [2:0] idx, logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		frames.write_reg(idx, data);
	endtask

	// hold the tick stream until every pending pixel is out, then let the block go idle
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (frames.due_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// new register set for a random stretch: big eyes and the fastest speed dominate
	// so the phases turn over quickly
	task automatic random_settings();
		logic [7:0] eye_val, speed_val;
		int         r;
		if ($urandom_range(0, 1))
			write_reg(REG_RED, pick_level());
		if ($urandom_range(0, 1))
			write_reg(REG_GREEN, pick_level());
		if ($urandom_range(0, 1))
			write_reg(REG_BLUE, pick_level());
		r = $urandom_range(0, 9);
		case (r)
			0:       eye_val = 8'd0;
			1:       eye_val = 8'($urandom_range(64, 255));   // upper data bits dropped
			2:       eye_val = 8'($urandom_range(59, 63));    // around the clip at MAX_EYE
			3, 4, 5, 6: eye_val = 8'($urandom_range(40, 61));
			default: eye_val = 8'($urandom_range(1, 63));
		endcase
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_EYE, eye_val);
		r = $urandom_range(0, 9);
		case (r)
			0, 1, 2, 3, 4, 5: speed_val = 8'd4;
			6:       speed_val = 8'($urandom_range(5, 7));    // clipped to the fastest
			7:       speed_val = 8'($urandom_range(8, 255));
			default: speed_val = 8'($urandom_range(0, 3));
		endcase
		write_reg(REG_SPEED, speed_val);
		if ($urandom_range(0, 4) == 0)
			write_reg(NO_REG_FIRST + 3'($urandom_range(0, 2)), 8'($urandom));
		cfg_valid <= 1'b0;
		calm = ($urandom_range(0, 3) == 0);
		settings_used++;
	endtask

	initial begin : stimulus
		int n;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset, speed register past its range
		write_reg(REG_SPEED, 8'd7);
		cfg_valid <= 1'b0;
		send_tick(1'b0);
		send_tick(1'b1);
		settle();

		// border-only eye, dim level rounding to zero
		write_reg(REG_RED, 8'd0);
		write_reg(REG_GREEN, 8'd255);
		write_reg(REG_BLUE, 8'd9);
		write_reg(REG_EYE, 8'd0);
		cfg_valid <= 1'b0;
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		repeat (3) send_tick(1'b1);
		settle();

		// oversized eye clipped to MAX_EYE, unknown register indexes
		write_reg(REG_EYE, 8'hFF);
		write_reg(NO_REG_FIRST, 8'hAA);
		write_reg(NO_REG_FIRST + 3'd2, 8'h55);
		write_reg(REG_RED, 8'd255);
		write_reg(REG_BLUE, 8'd10);
		cfg_valid <= 1'b0;
		repeat (5) send_tick(1'b1);
		settle();

		// one-pixel eye, slowest speed via masked data bits
		write_reg(REG_EYE, 8'd1);
		write_reg(REG_GREEN, 8'd0);
		write_reg(REG_BLUE, 8'd254);
		write_reg(REG_SPEED, 8'hF8);
		cfg_valid <= 1'b0;
		repeat (5) send_tick(1'b1);

		// random stretches, each under a fresh register set, drained in between
		while (items_sent < ITEM_COUNT) begin
			settle();
			random_settings();
			n = $urandom_range(15, 40);
			if (n > ITEM_COUNT - items_sent)
				n = ITEM_COUNT - items_sent;
			repeat (n) send_tick($urandom_range(0, 99) < 88);
		end
		settle();

		$display("run covered %0d tick items (%0d ticks), %0d frames, %0d pixel items checked",
			items_sent, frames.ticks, frames.frames, frames.pixels_checked);
		$display("%0d register sets, %0d phase changes, %0d mismatches",
			settings_used, frames.phase_turns, frames.errors);
		if (frames.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
